/* sv/prdtq_pkg.sv */
package prdtq_pkg;

  localparam int READY_DEPTH_DEF = 16;
  localparam int DELAY_DEPTH_DEF = 16;

  localparam logic [1:0] OP_ENQUEUE  = 2'd0;
  localparam logic [1:0] OP_RERUN    = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_DISPATCH = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_READY_FULL  = 3'd1;
  localparam logic [2:0] ST_DELAY_FULL  = 3'd2;
  localparam logic [2:0] ST_READY_EMPTY = 3'd3;
  localparam logic [2:0] ST_NO_CURRENT  = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  task_id;
    logic [7:0]  priority_req;
    logic [15:0] delay;
  } in_item_t;

  typedef struct packed {
    logic       dispatched;
    logic [7:0] out_task_id;
    logic [7:0] out_priority;
    logic [2:0] status;
    logic [4:0] ready_count;
  } out_item_t;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] prio;
  } task_t;

  // Command broadcast to every ready cell.
  typedef struct packed {
    logic  ins;
    logic  pop;
    task_t tsk;
  } rdy_cmd_t;

  // Command broadcast to every delay cell.
  typedef struct packed {
    logic        push;
    logic        dec;
    logic [15:0] ticks;
    task_t       tsk;
  } dly_cmd_t;

endpackage

/* sv/prdtq_ready_cell.sv */
module prdtq_ready_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  prdtq_pkg::rdy_cmd_t cmd,
  input  logic                left_valid,
  input  prdtq_pkg::task_t    left_tsk,
  input  logic                left_ge,
  input  logic                right_valid,
  input  prdtq_pkg::task_t    right_tsk,
  output logic                valid,
  output prdtq_pkg::task_t    tsk,
  output logic                ge
);
  import prdtq_pkg::*;

  logic  valid_r, valid_nxt;
  task_t tsk_r, tsk_nxt;

  // An occupied cell whose priority is not below the new one keeps its place.
  assign ge = valid_r && (tsk_r.prio >= cmd.tsk.prio);

  always_comb begin
    valid_nxt = valid_r;
    tsk_nxt   = tsk_r;
    if (cmd.pop) begin
      valid_nxt = right_valid;
      tsk_nxt   = right_tsk;
    end else if (cmd.ins && !ge && left_ge) begin
      valid_nxt = 1'b1;
      tsk_nxt   = cmd.tsk;
    end else if (cmd.ins && !ge && !left_ge) begin
      valid_nxt = left_valid;
      tsk_nxt   = left_tsk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    tsk_r <= tsk_nxt;
  end

  assign valid = valid_r;
  assign tsk   = tsk_r;
endmodule

/* sv/prdtq_delay_cell.sv */
module prdtq_delay_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  prdtq_pkg::dly_cmd_t cmd,
  input  logic                left_valid,
  input  logic                right_valid,
  input  logic [15:0]         right_ticks,
  input  prdtq_pkg::task_t    right_tsk,
  input  logic                compact,
  output logic                valid,
  output logic [15:0]         ticks,
  output prdtq_pkg::task_t    tsk
);
  import prdtq_pkg::*;

  logic        valid_r, valid_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  task_t       tsk_r, tsk_nxt;

  always_comb begin
    valid_nxt = valid_r;
    ticks_nxt = ticks_r;
    tsk_nxt   = tsk_r;
    if (cmd.push && !valid_r && left_valid) begin
      valid_nxt = 1'b1;
      ticks_nxt = cmd.ticks;
      tsk_nxt   = cmd.tsk;
    end else if (cmd.dec && valid_r) begin
      ticks_nxt = ticks_r - 16'd1;
    end else if (compact) begin
      // Shift one place towards the head; the head entry has left.
      valid_nxt = right_valid;
      ticks_nxt = right_ticks;
      tsk_nxt   = right_tsk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    ticks_r <= ticks_nxt;
    tsk_r   <= tsk_nxt;
  end

  assign valid = valid_r;
  assign ticks = ticks_r;
  assign tsk   = tsk_r;
endmodule

/* sv/priority_ready_and_delay_task_queue.sv */
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_ready   | in_item_t (operation, task_id, priority_req, delay)
// out_    | output    | out_valid/out_ready | out_item_t (one result per transaction)
//
// Enqueue, rerun and dispatch pass from the execute state to the output state, where
// the result is registered; the next transaction is accepted once it has been taken.
// A tick first decrements every live delay entry, then walks the live delay entries
// once, one per cycle, the head either expiring into the ready row (or being dropped
// with ST_READY_FULL when that row is full) or rotating to the end of the live entries.
// Reset (rst_n low, synchronous) empties both rows and clears the current task.
// One transaction is worked on at a time; a stalled result holds the next one.
module priority_ready_and_delay_task_queue #(
  parameter int READY_DEPTH = prdtq_pkg::READY_DEPTH_DEF,
  parameter int DELAY_DEPTH = prdtq_pkg::DELAY_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  prdtq_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output prdtq_pkg::out_item_t out_data
);
  import prdtq_pkg::*;

  localparam int RCW = $clog2(READY_DEPTH + 1);
  localparam int DCW = $clog2(DELAY_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]     state_r, state_nxt;
  in_item_t       item_r;
  logic [RCW-1:0] rfill_r, rfill_nxt;
  logic [DCW-1:0] dfill_r, dfill_nxt;
  logic [DCW-1:0] walk_r, walk_nxt;
  logic           cur_valid_r, cur_valid_nxt;
  task_t          cur_r, cur_nxt;
  logic [2:0]     status_r, status_nxt;
  logic           disp_r, disp_nxt;
  task_t          otsk_r, otsk_nxt;
  logic           out_valid_r, out_valid_nxt;

  rdy_cmd_t rcmd;
  dly_cmd_t dcmd;
  logic     dcompact;

  logic  rvalid [READY_DEPTH];
  task_t rtsk   [READY_DEPTH];
  logic  rge    [READY_DEPTH];
  logic        dvalid [DELAY_DEPTH];
  logic [15:0] dticks [DELAY_DEPTH];
  task_t       dtsk   [DELAY_DEPTH];
  logic        rotate;

  for (genvar g = 0; g < READY_DEPTH; g++) begin : g_rdy
    prdtq_ready_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (rcmd),
      .left_valid  ((g == 0) ? 1'b1 : rvalid[(g == 0) ? 0 : g - 1]),
      .left_tsk    (rtsk[(g == 0) ? 0 : g - 1]),
      .left_ge     ((g == 0) ? 1'b1 : rge[(g == 0) ? 0 : g - 1]),
      .right_valid ((g == READY_DEPTH - 1) ? 1'b0 : rvalid[(g == READY_DEPTH - 1) ? g : g + 1]),
      .right_tsk   (rtsk[(g == READY_DEPTH - 1) ? g : g + 1]),
      .valid       (rvalid[g]),
      .tsk         (rtsk[g]),
      .ge          (rge[g])
    );
  end

  // During a walk the head moves out and, when still pending, re-enters just
  // behind the other live entries, so the live part rotates and keeps its order.
  for (genvar g = 0; g < DELAY_DEPTH; g++) begin : g_dly
    logic        rv;
    logic [15:0] rt;
    task_t       rk;
    always_comb begin
      rv = (g == DELAY_DEPTH - 1) ? 1'b0 : dvalid[(g == DELAY_DEPTH - 1) ? g : g + 1];
      rt = dticks[(g == DELAY_DEPTH - 1) ? g : g + 1];
      rk = dtsk[(g == DELAY_DEPTH - 1) ? g : g + 1];
      if (rotate && (dfill_r == DCW'(g + 1))) begin
        rv = 1'b1;
        rt = dticks[0];
        rk = dtsk[0];
      end
    end
    prdtq_delay_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (dcmd),
      .left_valid  ((g == 0) ? 1'b1 : dvalid[(g == 0) ? 0 : g - 1]),
      .right_valid (rv),
      .right_ticks (rt),
      .right_tsk   (rk),
      .compact     (dcompact),
      .valid       (dvalid[g]),
      .ticks       (dticks[g]),
      .tsk         (dtsk[g])
    );
  end

  logic rfull, dfull, expired;
  assign rfull   = (rfill_r == RCW'(READY_DEPTH));
  assign dfull   = (dfill_r == DCW'(DELAY_DEPTH));
  assign expired = (dticks[0] == 16'd0);

  always_comb begin
    state_nxt     = state_r;
    rfill_nxt     = rfill_r;
    dfill_nxt     = dfill_r;
    walk_nxt      = walk_r;
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    status_nxt    = status_r;
    disp_nxt      = disp_r;
    otsk_nxt      = otsk_r;
    out_valid_nxt = out_valid_r;
    rcmd          = '0;
    dcmd          = '0;
    dcompact      = 1'b0;
    rotate        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = ST_OK;
          disp_nxt   = 1'b0;
          otsk_nxt   = '0;
          state_nxt  = (in_data.operation == OP_TICK) ? S_DEC : S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        unique case (item_r.operation)
          OP_ENQUEUE: begin
            if (rfull) begin
              status_nxt = ST_READY_FULL;
            end else begin
              rcmd.ins     = 1'b1;
              rcmd.tsk.id   = item_r.task_id;
              rcmd.tsk.prio = item_r.priority_req;
              rfill_nxt    = rfill_r + RCW'(1);
            end
          end
          OP_RERUN: begin
            if (!cur_valid_r) begin
              status_nxt = ST_NO_CURRENT;
            end else begin
              cur_valid_nxt = 1'b0;
              if (dfull) begin
                status_nxt = ST_DELAY_FULL;
              end else begin
                dcmd.push  = 1'b1;
                dcmd.ticks = (item_r.delay == 16'd0) ? 16'd1 : item_r.delay;
                dcmd.tsk   = cur_r;
                dfill_nxt  = dfill_r + DCW'(1);
              end
            end
          end
          OP_DISPATCH: begin
            if (rfill_r == '0) begin
              status_nxt = ST_READY_EMPTY;
            end else begin
              rcmd.pop      = 1'b1;
              rfill_nxt     = rfill_r - RCW'(1);
              cur_valid_nxt = 1'b1;
              cur_nxt       = rtsk[0];
              otsk_nxt      = rtsk[0];
              disp_nxt      = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_DEC: begin
        dcmd.dec  = 1'b1;
        walk_nxt  = dfill_r;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (walk_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          walk_nxt = walk_r - DCW'(1);
          dcompact = 1'b1;
          if (expired) begin
            dfill_nxt = dfill_r - DCW'(1);
            if (rfull) begin
              status_nxt = ST_READY_FULL;
            end else begin
              rcmd.ins  = 1'b1;
              rcmd.tsk  = dtsk[0];
              rfill_nxt = rfill_r + RCW'(1);
            end
          end else begin
            rotate = 1'b1;
          end
        end
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        if (out_valid_r && out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rfill_r     <= '0;
      dfill_r     <= '0;
      walk_r      <= '0;
      cur_valid_r <= 1'b0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rfill_r     <= rfill_nxt;
      dfill_r     <= dfill_nxt;
      walk_r      <= walk_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= (state_r == S_OUT) ? out_valid_nxt : 1'b0;
    end
    status_r <= status_nxt;
    disp_r   <= disp_nxt;
    otsk_r   <= otsk_nxt;
    if (state_r == S_IDLE && in_valid) begin
      item_r <= in_data;
    end
  end

  assign in_ready                = (state_r == S_IDLE);
  assign out_valid               = out_valid_r;
  assign out_data.dispatched     = disp_r;
  assign out_data.out_task_id    = otsk_r.id;
  assign out_data.out_priority   = otsk_r.prio;
  assign out_data.status         = status_r;
  assign out_data.ready_count    = 5'(rfill_r);
endmodule

/* sv/prdtq_checker.sv */
module prdtq_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input prdtq_pkg::out_item_t out_data,
  input logic                 out_valid,
  input logic                 out_ready
);
  import prdtq_pkg::*;

  a_stable_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result waits");

  a_disp_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dispatched |-> out_data.status == ST_OK)
    else $error("dispatch with error status");

  a_nodisp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.dispatched |-> out_data.out_task_id == 8'd0 &&
    out_data.out_priority == 8'd0)
    else $error("payload not zero without dispatch");
endmodule

bind priority_ready_and_delay_task_queue prdtq_checker u_prdtq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_ready (out_ready)
);
